[src/binary_signature_scanner_macros.svh]
// Assertion macros for the binary signature scanner.
// Used by the top level; needs nothing else.
`ifndef BINARY_SIGNATURE_SCANNER_MACROS_SVH
`define BINARY_SIGNATURE_SCANNER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define BSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define BSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bss_pkg.sv]
// Package for the binary signature scanner: widths, defaults, signature tables
// and the match status struct. Depends on nothing.
`default_nettype none

package bss_pkg;

	localparam int BYTE_W                = 8;
	localparam int MASK_W                = 24;
	localparam int TABLE_COUNT           = 24;
	localparam int SIG_TABLE_LEN         = 22;
	localparam int NUM_SIGNATURES_DEF    = 24;
	localparam int MAX_SIGNATURE_LEN_DEF = 22;
	localparam int CODE_LEN              = 3;

	// Signature bytes, right-justified: byte 0 is the last character.
	typedef logic [SIG_TABLE_LEN-1:0][BYTE_W-1:0] sig_bytes_t;
	typedef logic [CODE_LEN-1:0][BYTE_W-1:0]      code_bytes_t;

	// mov cr0, rax
	localparam code_bytes_t CODE_SIG = 24'h0F22C0;

	localparam sig_bytes_t SIG_TABLE [TABLE_COUNT] = '{
		"/rep\x74ile/rep\x74ile",
		"KHOOK_",
		"is_proc_in\x76isible",
		"ROOTKIT syscal\x6c_table",
		"ROOTKIT sys_cal\x6c_table",
		"un_hija\x63k_execve",
		"Giving r00t",
		"[?] SCT:",
		"Example Rootkit",
		"givemeroot",
		" lilyof\x74hevalley",
		" u want to hide",
		"diamorp\x68ine_",
		"m0na\x64",
		"LKM rootkit",
		"_back\x64oor_user",
		"/home/haxor",
		"/etc/secretshadow",
		"hide pid command",
		"hide file command",
		"asm_hoo\x6b_remove_all",
		"r00tkit",
		"r00tk1t",
		"mo\x64ule_hide"
	};

	localparam int SIG_LEN [TABLE_COUNT] = '{
		16, 6, 17, 21, 22, 16, 11, 8, 15, 10, 16, 15,
		12, 5, 11, 14, 11, 17, 16, 17, 19, 7, 7, 11
	};

	// Per-byte match status from the comparator bank
	typedef struct packed {
		logic              code_hit;
		logic [MASK_W-1:0] str_hit;
	} match_t;

endpackage

`default_nettype wire

[src/bss_channels.sv]
// Valid/ready channel interfaces: image byte beats in, scan result beats out.
// Depends on bss_pkg.
`default_nettype none

interface bss_byte_if import bss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] image_byte;
	logic              in_text_region;
	logic              last_byte;

	modport source (output valid, image_byte, in_text_region, last_byte, input ready);
	modport sink   (input valid, image_byte, in_text_region, last_byte, output ready);
endinterface

interface bss_result_if import bss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              code_signature_hit;
	logic [MASK_W-1:0] string_hit_mask;
	logic              reject;

	modport source (output valid, code_signature_hit, string_hit_mask, reject, input ready);
	modport sink   (input valid, code_signature_hit, string_hit_mask, reject, output ready);
endinterface

`default_nettype wire

[src/binary_signature_scanner.sv]
// Result: the last image byte passes the input register, then the result register.
// Throughput: one image byte per cycle; the input register and result register
// part the two sides, so bytes keep flowing while a result waits, and only a
// further last byte stalls until the result register is taken.
// Reset: arst_n clears the window, hit flags and valid bits; region starts as text.
`default_nettype none

`include "binary_signature_scanner_macros.svh"

module binary_signature_scanner import bss_pkg::*; #(
	parameter int NUM_SIGNATURES    = NUM_SIGNATURES_DEF,
	parameter int MAX_SIGNATURE_LEN = MAX_SIGNATURE_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bss_byte_if.sink    in_bytes,
	bss_result_if.source result
);

	localparam int HIST_DEPTH = MAX_SIGNATURE_LEN - 1;
	localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              text_s1;
	logic              last_s1;

	logic                              adv;
	logic                              out_free;
	logic [HIST_DEPTH-1:0][BYTE_W-1:0] hist;
	logic [FILL_W-1:0]                 fill;
	match_t                            hits;

	logic              code_hit_q;
	logic [MASK_W-1:0] str_hits_q;
	logic              out_valid_q;
	logic              out_code_q;
	logic [MASK_W-1:0] out_mask_q;
	logic              out_reject_q;
	logic              code_all;
	logic [MASK_W-1:0] mask_all;

	// handshake: only a last byte waits, and only on a full result register
	assign out_free       = !out_valid_q || result.ready;
	assign adv            = valid_s1 && (!last_s1 || out_free);
	assign in_bytes.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_bytes.ready) begin
			valid_s1 <= in_bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_bytes.ready && in_bytes.valid) begin
			byte_s1 <= in_bytes.image_byte;
			text_s1 <= in_bytes.in_text_region;
			last_s1 <= in_bytes.last_byte;
		end
	end

	bss_window #(
		.HIST_DEPTH(HIST_DEPTH)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.cur_byte (byte_s1),
		.text     (text_s1),
		.last     (last_s1),
		.hist     (hist),
		.fill     (fill)
	);

	bss_matcher #(
		.NUM_SIGNATURES(NUM_SIGNATURES),
		.HIST_DEPTH    (HIST_DEPTH)
	) u_matcher (
		.cur_byte (byte_s1),
		.text     (text_s1),
		.hist     (hist),
		.fill     (fill),
		.hits     (hits)
	);

	// image totals including this byte
	assign code_all = code_hit_q | hits.code_hit;
	assign mask_all = str_hits_q | hits.str_hit;

	// hit accumulators, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_hit_q <= 1'b0;
			str_hits_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				code_hit_q <= 1'b0;
				str_hits_q <= '0;
			end else begin
				code_hit_q <= code_all;
				str_hits_q <= mask_all;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_code_q   <= code_all;
			out_mask_q   <= mask_all;
			out_reject_q <= code_all || (mask_all != '0);
		end
	end

	assign result.valid              = out_valid_q;
	assign result.code_signature_hit = out_code_q;
	assign result.string_hit_mask    = out_mask_q;
	assign result.reject             = out_reject_q;

	// checks
	`BSS_ASSERT_NOW(a_stall_only_on_last, clk, arst_n, !in_bytes.ready,
		valid_s1 && last_s1 && out_valid_q && !result.ready,
		"input stalled without a last byte waiting on a full result register")
	`BSS_ASSERT_NEXT(a_clear_after_last, clk, arst_n, adv && last_s1,
		!code_hit_q && (str_hits_q == '0) && out_valid_q,
		"hit state not cleared or result missing after the last byte")
	`BSS_ASSERT_NOW(a_reject_consistent, clk, arst_n, out_valid_q,
		out_reject_q == (out_code_q || (out_mask_q != '0)),
		"reject flag disagrees with the hit fields")

endmodule

`default_nettype wire

[src/bss_window.sv]
// Match window: byte history shift line, fill count and region tracking.
// Depends on bss_pkg.
`default_nettype none

module bss_window import bss_pkg::*; #(
	parameter int HIST_DEPTH = MAX_SIGNATURE_LEN_DEF - 1,
	localparam int FILL_W    = $clog2(HIST_DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [BYTE_W-1:0]                cur_byte,
	input  logic                             text,
	input  logic                             last,
	output logic [HIST_DEPTH-1:0][BYTE_W-1:0] hist,
	output logic [FILL_W-1:0]                fill
);

	logic [HIST_DEPTH-1:0][BYTE_W-1:0] hist_q;
	logic [FILL_W-1:0]                 fill_q;
	logic                              prev_text_q;
	logic [FILL_W-1:0]                 fill_next;

	// window restarts on a region change
	assign fill = (text != prev_text_q) ? '0 : fill_q;
	assign hist = hist_q;

	// saturating fill count
	assign fill_next = (fill == FILL_W'(HIST_DEPTH)) ? fill : fill + FILL_W'(1);

	// history shift line, newest byte at entry 0; gated by fill, so no reset
	always_ff @(posedge clk) begin
		if (step) begin
			hist_q <= {hist_q[HIST_DEPTH-2:0], cur_byte};
		end
	end

	// fill and region state; cleared after the last byte of an image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			prev_text_q <= 1'b1;
		end else if (step) begin
			if (last) begin
				fill_q      <= '0;
				prev_text_q <= 1'b1;
			end else begin
				fill_q      <= fill_next;
				prev_text_q <= text;
			end
		end
	end

endmodule

`default_nettype wire

[src/bss_matcher.sv]
// Parallel comparator bank: checks the current byte plus history against the
// code signature and the text signature table. Depends on bss_pkg.
`default_nettype none

module bss_matcher import bss_pkg::*; #(
	parameter int NUM_SIGNATURES = NUM_SIGNATURES_DEF,
	parameter int HIST_DEPTH     = MAX_SIGNATURE_LEN_DEF - 1,
	localparam int FILL_W        = $clog2(HIST_DEPTH + 1)
) (
	input  logic [BYTE_W-1:0]                 cur_byte,
	input  logic                              text,
	input  logic [HIST_DEPTH-1:0][BYTE_W-1:0] hist,
	input  logic [FILL_W-1:0]                 fill,
	output match_t                            hits
);

	// history entries that a table signature can reach
	localparam int CMP_N = (HIST_DEPTH < SIG_TABLE_LEN - 1) ? HIST_DEPTH : SIG_TABLE_LEN - 1;

	always_comb begin
		logic ok;
		hits = '0;

		// code signature, text bytes only
		ok = text && (int'(fill) >= CODE_LEN - 1) && (cur_byte == CODE_SIG[0]);
		for (int i = 0; i < CODE_LEN - 1; i++) begin
			ok = ok && (hist[i] == CODE_SIG[i+1]);
		end
		hits.code_hit = ok;

		// text signatures, read-only data bytes only
		for (int k = 0; k < TABLE_COUNT; k++) begin
			ok = !text && (k < NUM_SIGNATURES)
				&& (SIG_LEN[k] - 1 <= int'(fill))
				&& (SIG_LEN[k] - 1 <= HIST_DEPTH)
				&& (cur_byte == SIG_TABLE[k][0]);
			for (int i = 0; i < CMP_N; i++) begin
				if (i + 1 < SIG_LEN[k]) begin
					ok = ok && (hist[i] == SIG_TABLE[k][i+1]);
				end
			end
			hits.str_hit[k] = ok;
		end
	end

endmodule

`default_nettype wire
